/* rtl/core/bht_pkg.sv */
package bht_pkg;

    localparam int ELEMENT_COUNT = 8;
    localparam int ELEM_W        = 3;
    localparam int CELLS         = 6;
    localparam int DATA_W        = 64;
    localparam int ROUNDS_W      = 15;
    localparam int LIMIT_W       = 16;
    localparam int TDATA_OUT_W   = 80;

    localparam logic [ROUNDS_W-1:0] ROUNDS_CAP = '1;

    typedef struct packed {
        logic              wr_en;
        logic              wr_load;
        logic              prime;
        logic              step;
        logic              below_ok;
        logic              out_ld;
        logic [ELEM_W-1:0] elem;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] shape;
        logic       transposed;
        logic       inverted;
    } t_elem;

    // edge, corner 2, transposed edge inv, corner 1 inv,
    // edge inv, corner 2 inv, corner 1, transposed edge
    localparam t_elem ELEMENTS [ELEMENT_COUNT] = '{
        '{2'd0, 1'b0, 1'b0}, '{2'd2, 1'b0, 1'b0}, '{2'd0, 1'b1, 1'b1},
        '{2'd1, 1'b0, 1'b1}, '{2'd0, 1'b0, 1'b1}, '{2'd2, 1'b0, 1'b1},
        '{2'd1, 1'b0, 1'b0}, '{2'd0, 1'b1, 1'b0}
    };

    localparam logic CELL_VALUE [CELLS] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    localparam int SHAPE_DR [3][CELLS] = '{
        '{-1, -1, -1,  1,  1,  1},
        '{-1, -1,  0,  0,  1,  1},
        '{-1, -1,  0,  0,  1,  1}
    };

    localparam int SHAPE_DC [3][CELLS] = '{
        '{-1,  0,  1, -1,  0,  1},
        '{-1,  0, -1,  1,  0,  1},
        '{ 0,  1,  1, -1, -1,  0}
    };

    function automatic logic [DATA_W-1:0] shift_cols(input logic [DATA_W-1:0] row,
                                                     input int dc);
        logic [DATA_W-1:0] res;
        if (dc < 0) begin
            res = row << 1;
        end else if (dc > 0) begin
            res = row >> 1;
        end else begin
            res = row;
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] match_row(input logic [ELEM_W-1:0] elem,
                                                    input logic [DATA_W-1:0] above,
                                                    input logic [DATA_W-1:0] cur,
                                                    input logic [DATA_W-1:0] below,
                                                    input logic [DATA_W-1:0] wmask);
        t_elem             el;
        int                dr;
        int                dc;
        logic              want;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] m;
        el = ELEMENTS[elem];
        m  = cur;
        for (int i = 0; i < CELLS; i++) begin
            dr   = el.transposed ? SHAPE_DC[el.shape][i] : SHAPE_DR[el.shape][i];
            dc   = el.transposed ? SHAPE_DR[el.shape][i] : SHAPE_DC[el.shape][i];
            want = el.inverted ? !CELL_VALUE[i] : CELL_VALUE[i];
            src  = (dr < 0) ? above : ((dr > 0) ? below : cur);
            v    = shift_cols(src, dc) & wmask;
            m    = m & (want ? v : ~v);
        end
        return m & wmask;
    endfunction

endpackage

/* rtl/core/bht_dp.sv */
module bht_dp
    import bht_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                          i_clk,
    input  t_dp_cmd                       i_cmd,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_rd_addr,
    input  logic [MAX_WIDTH-1:0]          i_load_data,
    input  logic [MAX_WIDTH-1:0]          i_wmask,
    output logic                          o_match_any,
    output logic [MAX_WIDTH-1:0]          o_out_row
);

    logic [MAX_WIDTH-1:0] r_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] r_rd;
    logic [MAX_WIDTH-1:0] r_above;
    logic [MAX_WIDTH-1:0] r_cur;
    logic [MAX_WIDTH-1:0] r_out;

    logic [DATA_W-1:0]    below64;
    logic [DATA_W-1:0]    match64;
    logic [MAX_WIDTH-1:0] match;
    logic [MAX_WIDTH-1:0] wr_data;

    assign below64 = i_cmd.below_ok ? DATA_W'(r_rd) : '0;
    assign match64 = match_row(i_cmd.elem, DATA_W'(r_above), DATA_W'(r_cur), below64,
                               DATA_W'(i_wmask));
    assign match   = match64[MAX_WIDTH-1:0];
    assign wr_data = i_cmd.wr_load ? (i_load_data & i_wmask) : (r_cur & ~match);

    assign o_match_any = |match;
    assign o_out_row   = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prime) begin
            r_above <= '0;
            r_cur   <= r_rd;
        end else if (i_cmd.step) begin
            r_above <= r_cur;
            r_cur   <= r_rd;
        end
        if (i_cmd.out_ld) begin
            r_out <= r_rd;
        end
    end

endmodule

/* rtl/core/bht_ctrl.sv */
module bht_ctrl
    import bht_pkg::*;
#(
    parameter int MAX_HEIGHT = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_last,
    input  logic                            i_out_ready,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0] i_height,
    input  logic [LIMIT_W-1:0]              i_max_iter,
    input  logic                            i_match_any,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output logic                            o_out_last,
    output logic [ROUNDS_W-1:0]             o_rounds,
    output t_dp_cmd                         o_cmd,
    output logic [$clog2(MAX_HEIGHT)-1:0]   o_wr_addr,
    output logic [$clog2(MAX_HEIGHT)-1:0]   o_rd_addr
);

    localparam int CNT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = $clog2(MAX_HEIGHT);

    typedef enum logic [2:0] {
        S_LOAD, S_ROUND, S_PRIME0, S_PRIME1, S_SWEEP, S_ERD, S_ELD, S_EOUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_pos;
    logic [ELEM_W-1:0]   r_elem;
    logic [ROUNDS_W-1:0] r_rounds;
    logic                r_change;
    logic                r_any;

    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W-1:0]    pos1;
    logic [CNT_W:0]      pos2;
    logic                pos_last;
    logic                any_now;
    logic                limit_hit;

    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign pos1      = r_pos + CNT_W'(1);
    assign pos2      = {1'b0, r_pos} + (CNT_W+1)'(2);
    assign pos_last  = (pos1 == r_cnt);
    assign any_now   = r_any | i_match_any;
    assign limit_hit = !i_max_iter[LIMIT_W-1] && ({1'b0, r_rounds} >= i_max_iter);

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EOUT);
    assign o_out_last  = pos_last;
    assign o_rounds    = r_rounds;

    always_comb begin
        o_cmd      = '0;
        o_cmd.elem = r_elem;
        o_wr_addr  = r_pos[ADDR_W-1:0];
        o_rd_addr  = r_pos[ADDR_W-1:0];
        unique case (r_state)
            S_LOAD: begin
                o_cmd.wr_en   = i_in_valid;
                o_cmd.wr_load = 1'b1;
                o_wr_addr     = r_cnt[ADDR_W-1:0];
            end
            S_PRIME0: begin
                o_rd_addr = '0;
            end
            S_PRIME1: begin
                o_cmd.prime = 1'b1;
                o_rd_addr   = ADDR_W'(1);
            end
            S_SWEEP: begin
                o_cmd.step     = 1'b1;
                o_cmd.wr_en    = 1'b1;
                o_cmd.below_ok = !pos_last;
                o_rd_addr      = pos2[ADDR_W-1:0];
            end
            S_ELD: begin
                o_cmd.out_ld = 1'b1;
            end
            S_ROUND, S_ERD, S_EOUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_elem   <= '0;
            r_rounds <= '0;
            r_change <= 1'b0;
            r_any    <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        r_cnt <= cnt_inc;
                        if (i_in_last || (cnt_inc >= i_height)) begin
                            r_state  <= S_ROUND;
                            r_rounds <= '0;
                            r_change <= 1'b1;
                        end
                    end
                end
                S_ROUND: begin
                    if (!r_change || limit_hit) begin
                        r_pos   <= '0;
                        r_state <= S_ERD;
                    end else begin
                        if (r_rounds != ROUNDS_CAP) begin
                            r_rounds <= r_rounds + ROUNDS_W'(1);
                        end
                        r_change <= 1'b0;
                        r_elem   <= '0;
                        r_state  <= S_PRIME0;
                    end
                end
                S_PRIME0: begin
                    r_any   <= 1'b0;
                    r_state <= S_PRIME1;
                end
                S_PRIME1: begin
                    r_pos   <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (pos_last) begin
                        if (any_now) begin
                            r_change <= 1'b1;
                        end
                        if (r_elem == ELEM_W'(ELEMENT_COUNT - 1)) begin
                            r_state <= S_ROUND;
                        end else begin
                            r_elem  <= r_elem + ELEM_W'(1);
                            r_state <= S_PRIME0;
                        end
                    end else begin
                        r_pos <= pos1;
                        r_any <= any_now;
                    end
                end
                S_ERD: begin
                    r_state <= S_ELD;
                end
                S_ELD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (i_out_ready) begin
                        if (pos_last) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_pos   <= pos1;
                            r_state <= S_ERD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

/* rtl/core/binary_hitmiss_thinning_top.sv */
// Binary hit-or-miss thinning of an image of up to MAX_HEIGHT rows.
// Input stream: one image row per transaction, tlast on the final row.
// Rows are accepted back to back while loading; thinning starts after the row with tlast,
// or by itself once the row count reaches the configured height.
// Thinning runs in rounds of eight structuring elements; each element is
// one sweep over the simple dual-port image RAM. The round count is set
// by the image content and the max_iterations limit.
// Output stream: n transactions, thinned row in tdata[63:0], rounds run in
// tdata[78:64], tlast on the final row; each row is read from RAM through
// the ERD, ELD and EOUT states. While the receiver stalls, the current row is held.
// No input is taken while thinning or emitting.
// APB registers: 0x0 image_width, 0x4 image_height, 0x8 max_iterations.
// Reset clears the controller and loads width 64, height 64, limit -1; the
// image RAM is not cleared and needs no clearing pass.
module binary_hitmiss_thinning_top
    import bht_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // row_pixels[63:0]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // thinned_row[63:0], rounds_run[78:64]
    output logic                   m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int CNT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = $clog2(MAX_HEIGHT);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    logic [6:0]           r_width;
    logic [6:0]           r_height;
    logic [LIMIT_W-1:0]   r_limit;

    logic [6:0]           width_c;
    logic [6:0]           height_c;
    logic [MAX_WIDTH-1:0] wmask;

    t_dp_cmd              cmd;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 match_any;
    logic [MAX_WIDTH-1:0] out_row;
    logic [ROUNDS_W-1:0]  rounds;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd64;
            r_limit  <= '1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[6:0];
                REG_HEIGHT: r_height <= pwdata[6:0];
                REG_LIMIT:  r_limit  <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            REG_LIMIT:  prdata = 32'(r_limit);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_width == '0) begin
            width_c = 7'd1;
        end else if (r_width > 7'(MAX_WIDTH)) begin
            width_c = 7'(MAX_WIDTH);
        end else begin
            width_c = r_width;
        end
        if (r_height == '0) begin
            height_c = 7'd1;
        end else if (r_height > 7'(MAX_HEIGHT)) begin
            height_c = 7'(MAX_HEIGHT);
        end else begin
            height_c = r_height;
        end
        for (int k = 0; k < MAX_WIDTH; k++) begin
            wmask[k] = (7'(k) < width_c);
        end
    end

    bht_ctrl #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_height    (height_c[CNT_W-1:0]),
        .i_max_iter  (r_limit),
        .i_match_any (match_any),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .o_rounds    (rounds),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr)
    );

    bht_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_wr_addr   (wr_addr),
        .i_rd_addr   (rd_addr),
        .i_load_data (s_axis_tdata[MAX_WIDTH-1:0]),
        .i_wmask     (wmask),
        .o_match_any (match_any),
        .o_out_row   (out_row)
    );

    assign m_axis_tdata = {1'b0, rounds, DATA_W'(out_row)};

endmodule

/* tb/bht_checker.sv */
`timescale 1ns / 1ps

package bht_tb_pkg;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_LIMIT  = 2'd2
    } t_reg_idx;

    localparam int MAX_DIM = 64;

    // out-of-range sizes fold into 1..MAX_DIM
    function automatic int clamp_dim(input logic [6:0] v);
        if (v == 7'd0) begin
            return 1;
        end else if (v > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

endpackage

module bht_checker
    import bht_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);

    typedef enum int {
        SHAPE_EDGE    = 0,
        SHAPE_CORNER1 = 1,
        SHAPE_CORNER2 = 2
    } t_shape;

    typedef struct packed {
        logic [14:0] rounds;
        logic        last;
        logic [63:0] row;
    } t_thinned;

    localparam int ROUNDS_SAT = 32767;

    // row and column offsets of the six cells; first three want 0, last three want 1
    localparam int CELL_DR [3][6] = '{
        '{-1, -1, -1,  1,  1,  1},
        '{-1, -1,  0,  0,  1,  1},
        '{-1, -1,  0,  0,  1,  1}
    };
    localparam int CELL_DC [3][6] = '{
        '{-1,  0,  1, -1,  0,  1},
        '{-1,  0, -1,  1,  0,  1},
        '{ 0,  1,  1, -1, -1,  0}
    };

    localparam t_shape ELEM_SHAPE [8] = '{
        SHAPE_EDGE, SHAPE_CORNER2, SHAPE_EDGE, SHAPE_CORNER1,
        SHAPE_EDGE, SHAPE_CORNER2, SHAPE_CORNER1, SHAPE_EDGE
    };
    localparam bit ELEM_TRANS [8] = '{0, 0, 1, 0, 0, 0, 0, 1};
    localparam bit ELEM_INV   [8] = '{0, 0, 1, 1, 1, 1, 0, 0};

    logic [63:0]        img_rows [64];
    int                 row_count;
    logic [6:0]         cfg_width;
    logic [6:0]         cfg_height;
    logic signed [15:0] cfg_limit;
    t_thinned           thinned_q [$];

    function automatic logic [63:0] elem_hits(input int e, input logic [63:0] up,
                                              input logic [63:0] cur,
                                              input logic [63:0] dn,
                                              input logic [63:0] wm);
        logic [63:0] m;
        logic [63:0] src;
        logic [63:0] v;
        int          dr;
        int          dc;
        bit          want;
        m = cur;
        for (int i = 0; i < 6; i++) begin
            dr   = ELEM_TRANS[e] ? CELL_DC[ELEM_SHAPE[e]][i] : CELL_DR[ELEM_SHAPE[e]][i];
            dc   = ELEM_TRANS[e] ? CELL_DR[ELEM_SHAPE[e]][i] : CELL_DC[ELEM_SHAPE[e]][i];
            want = (i >= 3) ^ ELEM_INV[e];
            src  = (dr < 0) ? up : ((dr > 0) ? dn : cur);
            v    = ((dc < 0) ? (src << 1) : ((dc > 0) ? (src >> 1) : src)) & wm;
            m    = m & (want ? v : ~v);
        end
        return m & wm;
    endfunction

    // thins img_rows[0..n-1] in place, returns rounds run
    function automatic logic [14:0] thin_image(input int n, input int w);
        logic [63:0] wm;
        logic [63:0] prev;
        logic [63:0] cur;
        logic [63:0] dn;
        logic [63:0] hm;
        int          rounds;
        bit          changed;
        wm = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        for (int r = 0; r < n; r++) begin
            img_rows[r] = img_rows[r] & wm;
        end
        rounds  = 0;
        changed = 1'b1;
        while (changed) begin
            if (cfg_limit >= 0 && rounds >= int'(cfg_limit)) begin
                break;
            end
            if (rounds < ROUNDS_SAT) begin
                rounds++;
            end
            changed = 1'b0;
            for (int e = 0; e < 8; e++) begin
                prev = '0;
                for (int r = 0; r < n; r++) begin
                    cur = img_rows[r];
                    dn  = (r + 1 < n) ? img_rows[r+1] : '0;
                    hm  = elem_hits(e, prev, cur, dn, wm);
                    if (hm != '0) begin
                        changed = 1'b1;
                    end
                    img_rows[r] = cur & ~hm;
                    prev        = cur;
                end
            end
        end
        return rounds[14:0];
    endfunction

    always @(posedge i_clk) begin
        t_thinned    want;
        logic [14:0] rc;
        if (!i_rst_n) begin
            cfg_width  = 7'd64;
            cfg_height = 7'd64;
            cfg_limit  = -16'sd1;
            row_count  = 0;
            thinned_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_WIDTH:  cfg_width  = i_pwdata[6:0];
                    REG_HEIGHT: cfg_height = i_pwdata[6:0];
                    REG_LIMIT:  cfg_limit  = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (thinned_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("unexpected transaction: row %h last %b rounds %0d",
                                 i_m_tdata[63:0], i_m_tlast, i_m_tdata[78:64]);
                    end
                end else begin
                    want = thinned_q.pop_front();
                    if (i_m_tdata[63:0] !== want.row || i_m_tdata[78:64] !== want.rounds
                            || i_m_tdata[79] !== 1'b0 || i_m_tlast !== want.last) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("mismatch: exp row %h last %b rounds %0d pad 0",
                                     want.row, want.last, want.rounds);
                            $display("          got row %h last %b rounds %0d pad %b",
                                     i_m_tdata[63:0], i_m_tlast, i_m_tdata[78:64],
                                     i_m_tdata[79]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (row_count < MAX_DIM) begin
                    img_rows[row_count] = i_s_tdata;
                    row_count++;
                end
                if (i_s_tlast || row_count >= clamp_dim(cfg_height)) begin
                    rc = thin_image(row_count, clamp_dim(cfg_width));
                    for (int r = 0; r < row_count; r++) begin
                        thinned_q.push_back({rc, (r == row_count - 1), img_rows[r]});
                    end
                    row_count = 0;
                end
            end
        end
        o_pending = thinned_q.size();
    end

endmodule

/* tb/tb_binary_hitmiss_thinning_top.sv */
`timescale 1ns / 1ps

module tb_binary_hitmiss_thinning_top;
    import bht_pkg::*;
    import bht_tb_pkg::*;

    typedef enum int {
        ROW_RANDOM,
        ROW_SPARSE,
        ROW_SOLID,
        ROW_ZERO,
        ROW_RUN
    } t_row_style;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 3000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [3:0]             paddr         = '0;
    logic [31:0]            pwdata        = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int errors;
    int pending;
    int cycles;
    int w_eff = 64;
    int h_eff = 64;
    bit quiet;
    bit hold_go;

    binary_hitmiss_thinning_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bht_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tlast  (m_axis_tlast),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_binary_hitmiss_thinning_top: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // receiver: random gaps, one long hold-off on request
    always @(negedge i_clk) begin
        int  hold_left;
        int  gap_left;
        bit  hold_taken;
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (gap_left > 0) begin
            m_axis_tready <= 1'b0;
            gap_left--;
        end else begin
            m_axis_tready <= 1'b1;
            gap_left = pick_gap();
        end
    end

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_cfg(input int w, input int h, input logic [15:0] lim);
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_LIMIT, {16'd0, lim});
        w_eff = clamp_dim(w[6:0]);
        h_eff = clamp_dim(h[6:0]);
    endtask

    // starts and ends at a falling edge; tvalid stays high for a back-to-back row
    task automatic send_row(input logic [63:0] row, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_image(input int n, input bit use_last, input t_row_style sty);
        int          lo;
        int          hi;
        logic [63:0] row;
        lo = $urandom_range(0, w_eff - 1);
        hi = $urandom_range(lo, w_eff - 1);
        for (int r = 0; r < n; r++) begin
            case (sty)
                ROW_RANDOM: row = {$urandom, $urandom};
                ROW_SPARSE: row = {$urandom, $urandom} & {$urandom, $urandom}
                                  & {$urandom, $urandom};
                ROW_SOLID:  row = '1;
                ROW_ZERO:   row = '0;
                default: begin
                    // blob: a run of ones that drifts from row to row
                    if (lo > 0 && $urandom_range(0, 2) == 0) begin
                        lo--;
                    end else if (lo < hi && $urandom_range(0, 2) == 0) begin
                        lo++;
                    end
                    if (hi < w_eff - 1 && $urandom_range(0, 2) == 0) begin
                        hi++;
                    end else if (hi > lo && $urandom_range(0, 2) == 0) begin
                        hi--;
                    end
                    row = ((64'd2 << hi) - 64'd1) & ~((64'd1 << lo) - 64'd1);
                    if ($urandom_range(0, 7) == 0) begin
                        row = row ^ (64'd1 << $urandom_range(0, 63));
                    end
                end
            endcase
            send_row(row, use_last && (r == n - 1));
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        int         n;
        int         rows_left;
        int         w;
        int         h;
        int         r;
        bit         use_last;
        bit         paused;
        logic [15:0] lim;
        t_row_style sty;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // reset settings: full size, no round limit
        send_row('1, 1'b1);
        send_row('0, 1'b0);
        send_row('1, 1'b0);
        send_row({32{2'b10}}, 1'b1);
        send_image(4, 1'b1, ROW_RUN);

        // zero width and height fold to 1; every row is its own image
        wait_idle();
        write_cfg(0, 0, 16'd2);
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b0);

        // oversized width and height, zero round limit
        wait_idle();
        write_cfg(127, 100, 16'd0);
        send_image(4, 1'b1, ROW_RANDOM);

        // narrow image, too many rows, one round
        wait_idle();
        write_cfg(5, 3, 16'd1);
        send_image(3, 1'b0, ROW_SOLID);
        send_image(1, 1'b1, ROW_SOLID);

        wait_idle();
        write_cfg(64, 64, 16'h7fff);
        send_image(4, 1'b1, ROW_SOLID);

        wait_idle();
        write_cfg(8, 4, 16'h8000);
        send_image(4, 1'b1, ROW_RUN);

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            r = $urandom_range(0, 9);
            if (r < 6) begin
                w = $urandom_range(3, 16);
            end else if (r < 8) begin
                w = 64;
            end else if (r < 9) begin
                w = $urandom_range(17, 63);
            end else begin
                w = $urandom_range(0, 127);
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                h = $urandom_range(1, 8);
            end else if (r < 9) begin
                h = $urandom_range(9, 16);
            end else begin
                h = 64;
            end
            r = $urandom_range(0, 5);
            if (r < 3) begin
                lim = 16'hffff;
            end else if (r == 3) begin
                lim = 16'($urandom_range(0, 3));
            end else if (r == 4) begin
                lim = {1'b1, 15'($urandom)};
            end else begin
                lim = 16'h7fff;
            end
            write_cfg(w, h, lim);
            quiet = (ph == 5);
            if (ph == 2) begin
                hold_go = 1'b1;
            end
            paused    = 1'b0;
            rows_left = 8;
            while (rows_left > 0) begin
                n = $urandom_range(1, h_eff);
                if (n > 8 && $urandom_range(0, 3) != 0) begin
                    n = $urandom_range(1, 8);
                end
                r = $urandom_range(0, 19);
                if (r < 12) begin
                    sty = ROW_RUN;
                end else if (r < 15) begin
                    sty = ROW_RANDOM;
                end else if (r < 17) begin
                    sty = ROW_SPARSE;
                end else if (r < 19) begin
                    sty = ROW_SOLID;
                end else begin
                    sty = ROW_ZERO;
                end
                use_last = (n < h_eff) || ($urandom_range(0, 1) == 1);
                send_image(n, use_last, sty);
                rows_left -= n;
                if (ph == 4 && !paused) begin
                    paused = 1'b1;
                    s_axis_tvalid <= 1'b0;
                    do @(negedge i_clk); while (pending != 0);
                end
            end
        end
        quiet = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb_binary_hitmiss_thinning_top: done, clean");
        end else begin
            $display("tb_binary_hitmiss_thinning_top: done, errors");
        end
        $finish;
    end

endmodule
